/* src/cmosrtc_pkg.sv */
// Shared types, constants and helpers for the CMOS/RTC periodic interrupt block.
// Depends on nothing; used by the top level, the testbench checker and the testbench top.
package cmosrtc_pkg;

   localparam int STORE_DEPTH = 128;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int IDX_W       = 7;
   localparam int TICK_W      = 32;
   localparam int PERIOD_W    = 15;

   localparam logic [IDX_W:0]   DEPTH_LIM = (IDX_W + 1)'(STORE_DEPTH);

   localparam logic [IDX_W-1:0] REG_A = 7'd10;
   localparam logic [IDX_W-1:0] REG_B = 7'd11;
   localparam logic [IDX_W-1:0] REG_C = 7'd12;
   localparam logic [IDX_W-1:0] REG_D = 7'd13;

   localparam logic [7:0] RESET_A    = 8'h26;
   localparam logic [7:0] RESET_B    = 8'h02;
   localparam logic [7:0] RESET_D    = 8'h80;
   localparam logic [7:0] INDEX_READ = 8'hff;
   localparam logic [7:0] FLAGS_PF   = 8'hc0;

   localparam int BIT_UIP = 7;
   localparam int BIT_PIE = 6;

   typedef enum logic [2:0] {
      MODE_RD_INDEX = 3'd0,
      MODE_RD_DATA  = 3'd1,
      MODE_WR_INDEX = 3'd2,
      MODE_WR_DATA  = 3'd3,
      MODE_TICK     = 3'd4,
      MODE_DIRECT   = 3'd5
   } mode_type;

   function automatic logic [7:0] reset_byte(input logic [ADDR_W-1:0] addr);
      logic [7:0] value;
      value = 8'h00;
      if (addr == REG_A[ADDR_W-1:0]) begin
         value = RESET_A;
      end else if (addr == REG_B[ADDR_W-1:0]) begin
         value = RESET_B;
      end else if (addr == REG_D[ADDR_W-1:0]) begin
         value = RESET_D;
      end
      return value;
   endfunction

endpackage

/* src/cmos_rtc_periodic_interrupt.sv */
// Top level of the CMOS/RTC store with its periodic interrupt timer.
// The byte store is a single-port synchronous memory; uses cmosrtc_pkg.
//
// A request steps through RD_A, RD_B, RD_X and EXEC; EXEC holds while a result is
// stalled, and no new request is taken before idle. The single memory port reads
// register A, register B and the addressed byte or register C, then writes back.
// Reset clears control state, the timer and the per-entry valid bits at once, so
// unwritten entries read their reset values; no clearing pass is needed.
module cmos_rtc_periodic_interrupt (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // write_data[7:0], direct_address[14:8], zero[15]
   input  logic [2:0]  req_tuser,   // mode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // read_data[7:0], irq_pulse[8], zero[15:9]
);

   localparam int ADDR_W = cmosrtc_pkg::ADDR_W;
   localparam int IDX_W  = cmosrtc_pkg::IDX_W;
   localparam int TICK_W = cmosrtc_pkg::TICK_W;
   localparam int PER_W  = cmosrtc_pkg::PERIOD_W;
   localparam int DEPTH  = cmosrtc_pkg::STORE_DEPTH;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_RD_A = 5'b00010,
      ST_RD_B = 5'b00100,
      ST_RD_X = 5'b01000,
      ST_EXEC = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   cmosrtc_pkg::mode_type  mode_ff, mode_in;
   logic [7:0]             wdata_ff, wdata_in;
   logic [IDX_W-1:0]       daddr_ff, daddr_in;
   logic [IDX_W-1:0]       index_ff, index_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [TICK_W-1:0]      deadline_ff, deadline_in;
   logic [PER_W-1:0]       period_ff, period_in;
   logic [7:0]             a_ff, a_in;
   logic [7:0]             b_ff, b_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [8:0]             rsp_data_ff, rsp_data_in;

   logic [7:0]             mem_ff [DEPTH];
   logic [DEPTH-1:0]       valid_ff;
   logic [7:0]             rraw_ff;
   logic                   rvalid_ff;
   logic [ADDR_W-1:0]      raddr_ff;

   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic [7:0]             rdata;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [7:0]             wr_byte;
   logic                   go;
   logic                   idx_ok;
   logic                   daddr_ok;
   logic [TICK_W-1:0]      tick_next;
   logic [TICK_W-1:0]      diff;
   logic                   fire;
   logic [7:0]             a_new;
   logic [7:0]             b_new;
   logic [3:0]             code;
   logic [3:0]             code_adj;
   logic [PER_W-1:0]       period_new;
   logic [TICK_W-1:0]      period_wide;
   logic [TICK_W-1:0]      deadline_new;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

   assign rdata    = rvalid_ff ? rraw_ff : cmosrtc_pkg::reset_byte(raddr_ff);
   assign idx_ok   = ({1'b0, index_ff} < cmosrtc_pkg::DEPTH_LIM);
   assign daddr_ok = ({1'b0, daddr_ff} < cmosrtc_pkg::DEPTH_LIM);
   assign go       = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   assign tick_next = tick_ff + TICK_W'(1);
   assign diff      = tick_next - deadline_ff;
   assign fire      = b_ff[cmosrtc_pkg::BIT_PIE] && !diff[TICK_W-1];

   always_comb begin
      a_new = a_ff;
      b_new = b_ff;
      if (index_ff == cmosrtc_pkg::REG_A) begin
         a_new = {a_ff[cmosrtc_pkg::BIT_UIP], wdata_ff[6:0]};
      end else if (index_ff == cmosrtc_pkg::REG_B) begin
         b_new = wdata_ff;
      end
      code     = a_new[3:0];
      code_adj = (code <= 4'd2) ? (code + 4'd7) : code;
      period_new   = PER_W'(1) << (code_adj - 4'd1);
      period_wide  = TICK_W'(period_new);
      deadline_new = (tick_ff + period_wide) & ~(period_wide - TICK_W'(1));
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = cmosrtc_pkg::REG_A[ADDR_W-1:0];
      case (state_ff)
         ST_RD_A: begin
            rd_en = 1'b1;
         end
         ST_RD_B: begin
            rd_en   = 1'b1;
            rd_addr = cmosrtc_pkg::REG_B[ADDR_W-1:0];
         end
         ST_RD_X: begin
            rd_en   = 1'b1;
            rd_addr = (mode_ff == cmosrtc_pkg::MODE_RD_DATA) ? index_ff[ADDR_W-1:0]
                                                            : cmosrtc_pkg::REG_C[ADDR_W-1:0];
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      wdata_in     = wdata_ff;
      daddr_in     = daddr_ff;
      index_in     = index_ff;
      tick_in      = tick_ff;
      deadline_in  = deadline_ff;
      period_in    = period_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = index_ff[ADDR_W-1:0];
      wr_byte      = wdata_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in  = cmosrtc_pkg::mode_type'(req_tuser);
               wdata_in = req_tdata[7:0];
               daddr_in = req_tdata[14:8];
               state_in = ST_RD_A;
            end
         end
         ST_RD_A: begin
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            a_in     = rdata;
            state_in = ST_RD_X;
         end
         ST_RD_X: begin
            b_in     = rdata;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (go) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = 9'd0;
               case (mode_ff)
                  cmosrtc_pkg::MODE_RD_INDEX: begin
                     rsp_data_in = {1'b0, cmosrtc_pkg::INDEX_READ};
                  end
                  cmosrtc_pkg::MODE_RD_DATA: begin
                     rsp_data_in = {1'b0, idx_ok ? rdata : 8'h00};
                  end
                  cmosrtc_pkg::MODE_WR_INDEX: begin
                     index_in = wdata_ff[IDX_W-1:0];
                  end
                  cmosrtc_pkg::MODE_WR_DATA: begin
                     wr_en   = idx_ok;
                     wr_byte = (index_ff == cmosrtc_pkg::REG_A) ? a_new : wdata_ff;
                     if ((index_ff == cmosrtc_pkg::REG_A || index_ff == cmosrtc_pkg::REG_B)
                         && b_new[cmosrtc_pkg::BIT_PIE] && code != 4'd0) begin
                        period_in   = period_new;
                        deadline_in = deadline_new;
                     end
                  end
                  cmosrtc_pkg::MODE_TICK: begin
                     tick_in = tick_next;
                     if (fire) begin
                        wr_en       = 1'b1;
                        wr_addr     = cmosrtc_pkg::REG_C[ADDR_W-1:0];
                        wr_byte     = rdata | cmosrtc_pkg::FLAGS_PF;
                        deadline_in = deadline_ff + TICK_W'(period_ff);
                        rsp_data_in = 9'h100;
                     end
                  end
                  cmosrtc_pkg::MODE_DIRECT: begin
                     wr_en   = daddr_ok;
                     wr_addr = daddr_ff[ADDR_W-1:0];
                  end
                  default: begin
                     rsp_data_in = 9'd0;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_byte;
      end
      if (rd_en) begin
         rraw_ff  <= mem_ff[rd_addr];
         raddr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rvalid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         index_ff     <= '0;
         tick_ff      <= '0;
         deadline_ff  <= '0;
         period_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         index_ff     <= index_in;
         tick_ff      <= tick_in;
         deadline_ff  <= deadline_in;
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      wdata_ff    <= wdata_in;
      daddr_ff    <= daddr_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* src/cmosrtc_checker.sv */
// Port-level checker for the CMOS/RTC periodic interrupt block, with its bind.
// Sees only the top level's ports; depends on no package.
module cmosrtc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A stalled result transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // An interrupt result never carries read data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[7:0] == 8'h00 && rsp_tdata[15:9] == 7'd0)
      else $error("interrupt result carries data");

   // One request transaction at a time: the block is busy right after taking one.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !$rose(rsp_tvalid))
      else $error("request taken while busy");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("result pending after reset");

endmodule

bind cmos_rtc_periodic_interrupt cmosrtc_checker u_checker (.*);

/* tb/cmos_rtc_periodic_interrupt_checker.sv */
`timescale 1ns / 1ps
// Checker for cmos_rtc_periodic_interrupt: keeps a shadow copy of the CMOS store and timer,
// predicts each response from the request channel and compares it with the response channel.
// Depends on cmosrtc_pkg for the register indexes, reset bytes and mode codes.
module cmos_rtc_periodic_interrupt_checker
   import cmosrtc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // write_data[7:0], direct_address[14:8], zero[15]
   input  logic [2:0]  req_tuser,   // mode[2:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // read_data[7:0], irq_pulse[8], zero[15:9]
   output int          fail_count,
   output int          rsp_count,
   output int          irq_count,
   output int          outstanding
);

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_pulse;
   } rtc_rsp_t;

   logic [7:0]          shadow_store [STORE_DEPTH];
   logic [IDX_W-1:0]    shadow_index;
   logic [TICK_W-1:0]   shadow_ticks;
   logic [TICK_W-1:0]   shadow_deadline;
   logic [PERIOD_W-1:0] shadow_period;
   rtc_rsp_t            expected_rsp [$];

   function automatic void rearm_timer();
      logic [3:0]  code;
      logic [31:0] period;
      code = shadow_store[REG_A][3:0];
      if (shadow_store[REG_B][BIT_PIE] && code != 4'd0) begin
         if (code <= 4'd2) begin
            code = code + 4'd7;
         end
         period          = 32'd1 << (code - 4'd1);
         shadow_period   = period[PERIOD_W-1:0];
         shadow_deadline = (shadow_ticks + period) & ~(period - 32'd1);
      end
   endfunction

   function automatic rtc_rsp_t predict_access(input logic [2:0] mode, input logic [7:0] wdata,
                                               input logic [6:0] daddr);
      rtc_rsp_t    rsp;
      logic [31:0] diff;
      rsp = '0;
      case (mode)
         MODE_RD_INDEX: begin
            rsp.read_data = INDEX_READ;
         end
         MODE_RD_DATA: begin
            if (int'(shadow_index) < STORE_DEPTH) begin
               rsp.read_data = shadow_store[shadow_index];
            end
         end
         MODE_WR_INDEX: begin
            shadow_index = wdata[6:0];
         end
         MODE_WR_DATA: begin
            if (shadow_index == REG_A) begin
               shadow_store[REG_A] = {shadow_store[REG_A][BIT_UIP], wdata[6:0]};
               rearm_timer();
            end else if (shadow_index == REG_B) begin
               shadow_store[REG_B] = wdata;
               rearm_timer();
            end else if (int'(shadow_index) < STORE_DEPTH) begin
               shadow_store[shadow_index] = wdata;
            end
         end
         MODE_TICK: begin
            shadow_ticks = shadow_ticks + 32'd1;
            if (shadow_store[REG_B][BIT_PIE]) begin
               diff = shadow_ticks - shadow_deadline;
               if (!diff[31]) begin
                  shadow_store[REG_C] = shadow_store[REG_C] | FLAGS_PF;
                  rsp.irq_pulse       = 1'b1;
                  shadow_deadline     = shadow_deadline + 32'(shadow_period);
               end
            end
         end
         MODE_DIRECT: begin
            if (int'(daddr) < STORE_DEPTH) begin
               shadow_store[daddr] = wdata;
            end
         end
         default: begin
         end
      endcase
      return rsp;
   endfunction

   always @(posedge clock) begin
      rtc_rsp_t want;
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            shadow_store[i] = 8'h00;
         end
         shadow_store[REG_A] = RESET_A;
         shadow_store[REG_B] = RESET_B;
         shadow_store[REG_D] = RESET_D;
         shadow_index    = '0;
         shadow_ticks    = '0;
         shadow_deadline = '0;
         shadow_period   = '0;
         expected_rsp.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (expected_rsp.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response transaction, actual %h", $time, rsp_tdata);
            end else begin
               want = expected_rsp.pop_front();
               if (want.irq_pulse) begin
                  irq_count++;
               end
               if (rsp_tdata[7:0] !== want.read_data) begin
                  fail_count++;
                  $display("%0t: read_data mismatch, expected %h actual %h", $time,
                           want.read_data, rsp_tdata[7:0]);
               end
               if (rsp_tdata[8] !== want.irq_pulse) begin
                  fail_count++;
                  $display("%0t: irq_pulse mismatch, expected %b actual %b", $time,
                           want.irq_pulse, rsp_tdata[8]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_rsp.push_back(predict_access(req_tuser, req_tdata[7:0], req_tdata[14:8]));
         end
      end
      outstanding <= expected_rsp.size();
   end

endmodule

/* tb/tb_cmos_rtc_periodic_interrupt.sv */
`timescale 1ns / 1ps
// Top of the testbench for cmos_rtc_periodic_interrupt: drives directed and random port
// accesses and ticks under four handshake pressure phases and reports the verdict.
// Depends on cmosrtc_pkg, the block itself and cmos_rtc_periodic_interrupt_checker.
module tb_cmos_rtc_periodic_interrupt;
   import cmosrtc_pkg::*;

   localparam logic [2:0] MODE_SPARE_6 = 3'd6;
   localparam logic [2:0] MODE_SPARE_7 = 3'd7;
   localparam int         PHASE_ITEMS  = 150;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = 16'h0000;
   logic [2:0]  req_tuser  = 3'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   int fail_count;
   int rsp_count;
   int irq_count;
   int outstanding;
   int sent_items = 0;
   int idle_pct   = 0;
   int stall_pct  = 0;

   cmos_rtc_periodic_interrupt dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   cmos_rtc_periodic_interrupt_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .rsp_count   (rsp_count),
      .irq_count   (irq_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   initial begin
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

   task automatic send_access(input logic [2:0] mode, input logic [7:0] wdata,
                              input logic [6:0] daddr);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {1'b0, daddr, wdata};
      do begin
         @(posedge clock);
      end while (!req_tready);
      sent_items++;
   endtask

   initial begin
      int          seq;
      int          start;
      logic [7:0]  value;
      logic [3:0]  code;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_access(MODE_RD_INDEX, 8'h5a, 7'h25);
      // PIE set behind the timer's back leaves a zero period, so every tick fires.
      send_access(MODE_DIRECT, 8'h40, REG_B);
      repeat (3) send_access(MODE_TICK, 8'h00, 7'h7f);
      send_access(MODE_DIRECT, RESET_B, REG_B);
      send_access(MODE_WR_INDEX, {1'b1, REG_A}, 7'h00);
      send_access(MODE_RD_DATA, 8'hff, 7'h00);
      send_access(MODE_DIRECT, 8'ha3, REG_A);
      send_access(MODE_WR_DATA, 8'h05, 7'h7f);
      send_access(MODE_RD_DATA, 8'h00, 7'h7f);
      send_access(MODE_WR_INDEX, {1'b0, REG_B}, 7'h00);
      send_access(MODE_WR_DATA, 8'h42, 7'h00);
      send_access(MODE_WR_INDEX, {1'b0, REG_A}, 7'h00);
      send_access(MODE_WR_DATA, 8'h03, 7'h00);
      repeat (5) send_access(MODE_TICK, 8'hff, 7'h00);
      send_access(MODE_WR_INDEX, {1'b0, REG_C}, 7'h00);
      send_access(MODE_RD_DATA, 8'h00, 7'h00);
      send_access(MODE_WR_INDEX, 8'hff, 7'h7f);
      send_access(MODE_WR_DATA, 8'hff, 7'h7f);
      send_access(MODE_RD_DATA, 8'h00, 7'h00);
      send_access(MODE_DIRECT, 8'hff, 7'h00);
      send_access(MODE_DIRECT, 8'h00, 7'h7f);
      send_access(MODE_SPARE_6, 8'hff, 7'h7f);
      send_access(MODE_SPARE_7, 8'h00, 7'h00);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 52; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 52; end
            default: begin idle_pct = 34; stall_pct = 34; end
         endcase
         start = sent_items;
         while (sent_items - start < PHASE_ITEMS) begin
            seq = $urandom_range(0, 99);
            if (seq < 15) begin
               code = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(3, 6))
                                                : 4'($urandom_range(0, 15));
               value = 8'($urandom_range(0, 255));
               send_access(MODE_WR_INDEX, {1'($urandom_range(0, 1)), REG_A},
                           7'($urandom_range(0, 127)));
               send_access(MODE_WR_DATA, {value[7:4], code}, 7'($urandom_range(0, 127)));
               value = 8'($urandom_range(0, 255));
               value[BIT_PIE] = ($urandom_range(0, 9) < 8);
               send_access(MODE_WR_INDEX, {1'($urandom_range(0, 1)), REG_B},
                           7'($urandom_range(0, 127)));
               send_access(MODE_WR_DATA, value, 7'($urandom_range(0, 127)));
            end else if (seq < 55) begin
               repeat ($urandom_range(1, 24)) begin
                  send_access(MODE_TICK, 8'($urandom_range(0, 255)),
                              7'($urandom_range(0, 127)));
               end
            end else if (seq < 75) begin
               value = ($urandom_range(0, 9) < 7)
                       ? {1'($urandom_range(0, 1)), 7'($urandom_range(10, 13))}
                       : 8'($urandom_range(0, 255));
               send_access(MODE_WR_INDEX, value, 7'($urandom_range(0, 127)));
               send_access(MODE_RD_DATA, 8'($urandom_range(0, 255)),
                           7'($urandom_range(0, 127)));
               if ($urandom_range(0, 9) < 3) begin
                  send_access(MODE_RD_INDEX, 8'($urandom_range(0, 255)),
                              7'($urandom_range(0, 127)));
               end
            end else if (seq < 85) begin
               send_access(MODE_WR_INDEX, 8'($urandom_range(0, 255)),
                           7'($urandom_range(0, 127)));
               send_access(MODE_WR_DATA, 8'($urandom_range(0, 255)),
                           7'($urandom_range(0, 127)));
            end else if (seq < 93) begin
               send_access(MODE_DIRECT, 8'($urandom_range(0, 255)),
                           ($urandom_range(0, 3) == 0) ? 7'($urandom_range(10, 13))
                                                       : 7'($urandom_range(0, 127)));
            end else begin
               send_access(($urandom_range(0, 1) == 0) ? MODE_SPARE_6 : MODE_SPARE_7,
                           8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
            end
         end
      end

      req_tvalid <= 1'b0;
      do begin
         @(posedge clock);
      end while (outstanding != 0);
      repeat (20) @(posedge clock);

      $display("Checked %0d responses to %0d accepted accesses and ticks, %0d of them",
               rsp_count, sent_items, irq_count);
      $display("periodic interrupts, across four sender idle and receiver stall phases.");
      if (fail_count == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* sim.f */
src/cmosrtc_pkg.sv
src/cmos_rtc_periodic_interrupt.sv
src/cmosrtc_checker.sv
tb/cmos_rtc_periodic_interrupt_checker.sv
tb/tb_cmos_rtc_periodic_interrupt.sv
